>>> hw/rtl/ssm_pkg.sv
// shared types, constants and helpers for the substring search matcher
package ssm_pkg;

    localparam int PIDX_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int START_W    = 20;
    localparam int MLEN_W     = 5;
    localparam int CFG_LEN_W  = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_BACKWARD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IGNORE_CASE     = 2'd2;

    typedef struct packed {
        logic [CFG_LEN_W-1:0] pattern_len;
        logic                 search_backward;
        logic                 ignore_case;
    } ssm_cfg_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                    input logic ic);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ic && (c >= 8'h61) && (c <= 8'h7a))
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ssm_if.sv
// valid/ready channel interfaces for input items and results
interface ssm_in_if import ssm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [PIDX_W-1:0] pattern_index;
    logic [BYTE_W-1:0] data_byte;
    logic              last_text;

    modport source (output valid, cmd, pattern_index, data_byte, last_text, input ready);
    modport sink   (input valid, cmd, pattern_index, data_byte, last_text, output ready);
endinterface

interface ssm_out_if import ssm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] match_start;
    logic [MLEN_W-1:0]  match_length;
    logic               overflow;

    modport source (output valid, found, match_start, match_length, overflow, input ready);
    modport sink   (input valid, found, match_start, match_length, overflow, output ready);
endinterface

>>> hw/rtl/substring_search_matcher.sv
// top level: input stage, region tracking and result register
//
//  channel   dir  handshake      payload
//  item      in   valid/ready    cmd, pattern_index, data_byte, last_text
//  result    out  valid/ready    found, match_start, match_length, overflow
//  apb       in   psel/penable   pattern_len, search_backward, ignore_case
//
// one item per cycle unless the input stage stalls; the last text byte of a region
// passes the input register, then compare and tracking logic into the result register
// reset clears the window, region state and config; the pattern store is not reset
// the input stage stalls only when it holds a region end and the result register is
// full and not taken; everything else keeps flowing
module substring_search_matcher import ssm_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ssm_in_if.sink                item,
    ssm_out_if.source             result
);

    localparam int LenW = $clog2(MAX_PATTERN + 1);
    localparam int CmpW = (LenW > CFG_LEN_W) ? LenW : CFG_LEN_W;
    localparam logic [POSITION_BITS-1:0] Cap = '1;

    ssm_cfg_t cfg;

    logic              stage_valid_reg;
    logic              stage_cmd_reg;
    logic [PIDX_W-1:0] stage_pidx_reg;
    logic [BYTE_W-1:0] stage_byte_reg;
    logic              stage_last_reg;

    logic [POSITION_BITS-1:0] count_reg;
    logic                     hit_seen_reg;
    logic [POSITION_BITS-1:0] hit_start_reg;
    logic                     overflow_seen_reg;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [START_W-1:0] out_start_reg;
    logic [MLEN_W-1:0]  out_len_reg;
    logic               out_ovf_reg;

    logic [LenW-1:0]          eff_len;
    logic                     advance;
    logic                     is_text;
    logic                     room;
    logic                     shift_en;
    logic                     load_en;
    logic                     emit;
    logic                     all_match;
    logic                     take;
    logic [POSITION_BITS-1:0] count_inc;
    logic [POSITION_BITS-1:0] count_now;
    logic [POSITION_BITS-1:0] len_p;
    logic                     hit_seen_next;
    logic [POSITION_BITS-1:0] hit_start_next;
    logic                     overflow_next;
    logic                     found_next;
    logic [POSITION_BITS-1:0] start_next;
    logic [MLEN_W-1:0]        mlen_next;
    logic [POSITION_BITS+START_W-1:0] start_ext;

    ssm_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign eff_len = (CmpW'(cfg.pattern_len) > CmpW'(MAX_PATTERN))
                   ? LenW'(MAX_PATTERN) : LenW'(cfg.pattern_len);

    // stage moves unless it holds a region end facing a blocked result register
    assign advance = stage_valid_reg
        && !(stage_cmd_reg == CMD_TEXT && stage_last_reg && out_valid_reg && !result.ready);
    assign item.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            stage_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            stage_cmd_reg  <= item.cmd;
            stage_pidx_reg <= item.pattern_index;
            stage_byte_reg <= item.data_byte;
            stage_last_reg <= item.last_text;
        end
    end

    assign is_text   = stage_cmd_reg == CMD_TEXT;
    assign room      = count_reg != Cap;
    assign shift_en  = advance && is_text && room;
    assign load_en   = advance && !is_text;
    assign emit      = advance && is_text && stage_last_reg;
    assign count_inc = count_reg + 1'b1;
    assign len_p     = POSITION_BITS'(eff_len);

    ssm_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LenW)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_en       (load_en),
        .shift_en      (shift_en),
        .clear_en      (emit),
        .pattern_index (stage_pidx_reg),
        .data_byte     (stage_byte_reg),
        .eff_len       (eff_len),
        .ignore_case   (cfg.ignore_case),
        .all_match     (all_match)
    );

    always_comb
    begin
        take = shift_en && (eff_len != '0) && (count_inc >= len_p) && all_match
            && (cfg.search_backward || !hit_seen_reg);
        hit_seen_next  = hit_seen_reg || take;
        hit_start_next = take ? (count_inc - len_p) : hit_start_reg;
        count_now      = room ? count_inc : count_reg;
        overflow_next  = overflow_seen_reg || !room;

        if (eff_len == '0)
        begin
            found_next = 1'b1;
            start_next = cfg.search_backward ? count_now : '0;
            mlen_next  = '0;
        end
        else if (hit_seen_next)
        begin
            found_next = 1'b1;
            start_next = hit_start_next;
            mlen_next  = MLEN_W'(eff_len);
        end
        else
        begin
            found_next = 1'b0;
            start_next = '0;
            mlen_next  = '0;
        end
        start_ext = {{START_W{1'b0}}, start_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            hit_seen_reg      <= 1'b0;
            hit_start_reg     <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (emit)
        begin
            count_reg         <= '0;
            hit_seen_reg      <= 1'b0;
            hit_start_reg     <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (advance && is_text)
        begin
            count_reg         <= count_now;
            hit_seen_reg      <= hit_seen_next;
            hit_start_reg     <= hit_start_next;
            overflow_seen_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_found_reg <= found_next;
            out_start_reg <= start_ext[START_W-1:0];
            out_len_reg   <= mlen_next;
            out_ovf_reg   <= overflow_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = out_found_reg;
    assign result.match_start  = out_start_reg;
    assign result.match_length = out_len_reg;
    assign result.overflow     = out_ovf_reg;

endmodule

>>> hw/rtl/ssm_cfg.sv
// apb configuration registers
module ssm_cfg import ssm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output ssm_cfg_t              cfg
);

    ssm_cfg_t             cfg_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_LEN:     cfg_reg.pattern_len     <= pwdata[CFG_LEN_W-1:0];
                REG_SEARCH_BACKWARD: cfg_reg.search_backward <= pwdata[0];
                REG_IGNORE_CASE:     cfg_reg.ignore_case     <= pwdata[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_LEN:     prdata = APB_DATA_W'(cfg_reg.pattern_len);
            REG_SEARCH_BACKWARD: prdata = APB_DATA_W'(cfg_reg.search_backward);
            REG_IGNORE_CASE:     prdata = APB_DATA_W'(cfg_reg.ignore_case);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/ssm_window.sv
// pattern store, text window shift line and parallel window compare
module ssm_window import ssm_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic              shift_en,
    input  logic              clear_en,
    input  logic [PIDX_W-1:0] pattern_index,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LEN_W-1:0]  eff_len,
    input  logic              ignore_case,
    output logic              all_match
);

    logic [BYTE_W-1:0]             pat_reg   [MAX_PATTERN];
    logic [BYTE_W-1:0]             win_reg   [MAX_PATTERN];
    logic [BYTE_W-1:0]             win_next  [MAX_PATTERN];
    logic [MAX_PATTERN*BYTE_W-1:0] rev_flat;
    logic [MAX_PATTERN*BYTE_W-1:0] aligned_flat;
    logic [LEN_W-1:0]              shift_amt;
    logic [MAX_PATTERN-1:0]        pos_ok;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (load_en && (int'(pattern_index) == k))
            begin
                pat_reg[k] <= data_byte;
            end
        end
    end

    // window after the incoming byte is shifted in
    always_comb
    begin
        win_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_next[k] = win_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (clear_en)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // pattern byte i lines up with window byte len-1-i
    assign shift_amt = LEN_W'(MAX_PATTERN) - eff_len;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            rev_flat[k*BYTE_W +: BYTE_W] = win_next[MAX_PATTERN-1-k];
        end
        aligned_flat = rev_flat >> {shift_amt, 3'b000};
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos_ok[i] = (LEN_W'(i) >= eff_len)
                || (fold_byte(pat_reg[i], ignore_case)
                    == fold_byte(aligned_flat[i*BYTE_W +: BYTE_W], ignore_case));
        end
    end

    assign all_match = &pos_ok;

endmodule

>>> hw/rtl/ssm_checker.sv
// port-level checks for the substring search matcher, bound to the top level
module ssm_port_checks import ssm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic               found,
    input logic [START_W-1:0] match_start,
    input logic [MLEN_W-1:0]  match_length,
    input logic               overflow
);

    // a pending result transaction holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(found) && $stable(match_start)
            && $stable(match_length) && $stable(overflow))
        else $error("result changed while stalled");

    // input backpressure only comes from a blocked result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid && !result_ready)
        else $error("input stalled without a blocked result");

    // a miss reports zero offset and length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> match_start == '0 && match_length == '0)
        else $error("miss with nonzero offset or length");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind substring_search_matcher ssm_port_checks u_ssm_port_checks
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .found        (result.found),
    .match_start  (result.match_start),
    .match_length (result.match_length),
    .overflow     (result.overflow)
);

>>> dv/ssm_checker.sv
// substring search matcher checker: predicts every search result and compares it
module ssm_checker import ssm_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    ssm_in_if                     item_mon,
    ssm_out_if                    result_mon,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // a region holds at most 2^POSITION_BITS - 1 counted bytes
    localparam logic [POSITION_BITS-1:0] TEXT_CAP = '1;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [MLEN_W-1:0]  mlen;
        logic               ovf;
    } search_rpt_t;

    search_rpt_t              rpt_q[$];
    search_rpt_t              want;
    ssm_cfg_t                 cfg;
    logic [BYTE_W-1:0]        pat_mem [MAX_PATTERN];
    logic [BYTE_W-1:0]        win [MAX_PATTERN];
    logic [POSITION_BITS-1:0] txt_cnt;
    logic [POSITION_BITS-1:0] hit_pos;
    logic                     hit_seen;
    logic                     ovf_seen;

    function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] b);
        // 'a'..'z' only
        if (cfg.ignore_case && b >= 8'h61 && b <= 8'h7a)
        begin
            return b - 8'h20;
        end
        return b;
    endfunction

    function automatic int active_len();
        return (cfg.pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(cfg.pattern_len);
    endfunction

    // pattern byte 0 lines up with the oldest byte of the window
    function automatic bit window_hit(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (upcase(pat_mem[i]) != upcase(win[n - 1 - i]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_region();
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win[i] = '0;
        end
        txt_cnt  = '0;
        hit_pos  = '0;
        hit_seen = 1'b0;
        ovf_seen = 1'b0;
    endtask

    task automatic take_text(input logic [BYTE_W-1:0] b, input logic last);
        int          n;
        search_rpt_t r;
        n = active_len();
        if (txt_cnt < TEXT_CAP)
        begin
            for (int i = MAX_PATTERN - 1; i > 0; i--)
            begin
                win[i] = win[i - 1];
            end
            win[0]  = b;
            txt_cnt = txt_cnt + 1'b1;
            if (n > 0 && txt_cnt >= n && window_hit(n))
            begin
                if (cfg.search_backward || !hit_seen)
                begin
                    hit_seen = 1'b1;
                    hit_pos  = txt_cnt - POSITION_BITS'(n);
                end
            end
        end
        else
        begin
            ovf_seen = 1'b1;
        end
        if (last)
        begin
            if (n == 0)
            begin
                r.found = 1'b1;
                r.start = cfg.search_backward ? txt_cnt : '0;
                r.mlen  = '0;
            end
            else if (hit_seen)
            begin
                r.found = 1'b1;
                r.start = hit_pos;
                r.mlen  = MLEN_W'(n);
            end
            else
            begin
                r.found = 1'b0;
                r.start = '0;
                r.mlen  = '0;
            end
            r.ovf = ovf_seen;
            rpt_q.push_back(r);
            clear_region();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_region();
            cfg        = '0;
            fail_count = 0;
            rpt_q.delete();
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_PATTERN_LEN:     cfg.pattern_len     = pwdata[CFG_LEN_W-1:0];
                    REG_SEARCH_BACKWARD: cfg.search_backward = pwdata[0];
                    REG_IGNORE_CASE:     cfg.ignore_case     = pwdata[0];
                    default:             ;
                endcase
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (rpt_q.size() == 0)
                begin
                    $error("result transaction with no search pending: found=%0d start=%0d",
                           result_mon.found, result_mon.match_start);
                    fail_count++;
                end
                else
                begin
                    want = rpt_q.pop_front();
                    if (result_mon.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, result_mon.found);
                        fail_count++;
                    end
                    if (result_mon.match_start !== want.start)
                    begin
                        $error("match_start: expected %0d, actual %0d",
                               want.start, result_mon.match_start);
                        fail_count++;
                    end
                    if (result_mon.match_length !== want.mlen)
                    begin
                        $error("match_length: expected %0d, actual %0d",
                               want.mlen, result_mon.match_length);
                        fail_count++;
                    end
                    if (result_mon.overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0d, actual %0d",
                               want.ovf, result_mon.overflow);
                        fail_count++;
                    end
                end
            end
            if (item_mon.valid && item_mon.ready)
            begin
                if (item_mon.cmd == CMD_PATTERN)
                begin
                    if (item_mon.pattern_index < MAX_PATTERN)
                    begin
                        pat_mem[item_mon.pattern_index] = item_mon.data_byte;
                    end
                end
                else
                begin
                    take_text(item_mon.data_byte, item_mon.last_text);
                end
            end
            pending <= rpt_q.size();
        end
    end

endmodule

>>> dv/tb.sv
// testbench top: stimulus, register setup and verdict for the substring search matcher
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssm_pkg::*;

    localparam int PAT_DEPTH   = 16;
    localparam int RAND_ITEMS  = 1820;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                fails;
    int                pending;
    int                sent;
    int                src_mode;
    bit                sink_free;
    int                act_len;
    logic [BYTE_W-1:0] pat_copy [PAT_DEPTH];

    ssm_in_if  item_ch ();
    ssm_out_if result_ch ();

    always #6 clk = ~clk;

    substring_search_matcher u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    ssm_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .item_mon   (item_ch),
        .result_mon (result_ch),
        .fail_count (fails),
        .pending    (pending)
    );

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 13))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'h40;  // just below 'A'
            3:       return 8'h5b;  // just above 'Z'
            4:       return 8'h60;  // just below 'a'
            5:       return 8'h7b;  // just above 'z'
            6:       return 8'h5a;
            7:       return 8'h7a;
            8, 9:    return BYTE_W'($urandom_range(0, 255));
            default: return 8'h41 + BYTE_W'($urandom_range(0, 1))
                            + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
        if (((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) && $urandom_range(0, 1))
        begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    task automatic send_item(input logic cmd, input logic [PIDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        case (src_mode)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 17);
            default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        endcase
        if (gap > 0)
        begin
            item_ch.valid         <= 1'b0;
            item_ch.cmd           <= 1'($urandom);
            item_ch.pattern_index <= PIDX_W'($urandom);
            item_ch.data_byte     <= BYTE_W'($urandom);
            item_ch.last_text     <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= cmd;
        item_ch.pattern_index <= idx;
        item_ch.data_byte     <= b;
        item_ch.last_text     <= last;
        do @(posedge clk); while (!item_ch.ready);
        sent++;
    endtask

    task automatic send_region(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(CMD_TEXT, '0, s[i], i == s.len() - 1);
        end
    endtask

    // drain all outstanding results, then give the pipeline time to empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int len, input bit bwd, input bit ic);
        settle();
        write_reg(REG_PATTERN_LEN, len);
        write_reg(REG_SEARCH_BACKWARD, APB_DATA_W'(bwd));
        write_reg(REG_IGNORE_CASE, APB_DATA_W'(ic));
        act_len = (len > PAT_DEPTH) ? PAT_DEPTH : len;
    endtask

    initial
    begin
        #10_000_000;
        $display("substring_search_matcher: mismatch");
        $finish;
    end

    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_free ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    initial
    begin
        int                len;
        int                nreg;
        int                rlen;
        int                pos;
        bit                plant_flip;
        logic [PIDX_W-1:0] idx;
        logic [BYTE_W-1:0] b;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_PATTERN;
        item_ch.pattern_index <= '0;
        item_ch.data_byte     <= '0;
        item_ch.last_text     <= 1'b0;
        sent      = 0;
        src_mode  = 1;
        sink_free = 1'b0;
        act_len   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern, forward: hit at offset 0
        send_item(CMD_TEXT, '0, 8'h00, 1'b0);
        send_item(CMD_TEXT, 4'hf, 8'hff, 1'b1);
        // pattern load carrying last_text gives no result
        send_item(CMD_PATTERN, 4'hf, 8'hff, 1'b1);
        // empty pattern, backward: hit at the region length
        settle();
        write_reg(REG_SEARCH_BACKWARD, 1);
        send_region("xyz");
        send_item(CMD_PATTERN, 4'd0, "a", 1'b0);
        send_item(CMD_PATTERN, 4'd1, "Z", 1'b0);
        settle();
        write_reg(REG_PATTERN_LEN, 2);
        write_reg(REG_IGNORE_CASE, 1);
        send_region("xAzqaz");
        settle();
        write_reg(REG_SEARCH_BACKWARD, 0);
        send_region("a");
        send_region("ZaZ");
        settle();
        write_reg(REG_IGNORE_CASE, 0);
        send_region("az");

        while (sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       len = 0;
                1:       len = PAT_DEPTH;
                2:       len = $urandom_range(PAT_DEPTH + 1, 31);
                default: len = $urandom_range(1, 8);
            endcase
            set_config(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            src_mode  = $urandom_range(0, 2);
            sink_free = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < act_len; i++)
            begin
                pat_copy[i] = pick_byte();
                send_item(CMD_PATTERN, PIDX_W'(i), pat_copy[i], $urandom_range(0, 3) == 0);
            end
            nreg = $urandom_range(1, 4);
            repeat (nreg)
            begin
                rlen = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(1, 24);
                pos = 0;
                while (pos < rlen)
                begin
                    if ($urandom_range(0, 29) == 0)
                    begin
                        // pattern rewrite in the middle of a region
                        idx = PIDX_W'($urandom_range(0, PAT_DEPTH - 1));
                        b   = pick_byte();
                        if (idx < act_len)
                        begin
                            pat_copy[idx] = b;
                        end
                        send_item(CMD_PATTERN, idx, b, 1'($urandom_range(0, 1)));
                    end
                    else if (act_len > 0 && $urandom_range(0, 2) == 0)
                    begin
                        // planted copy, possibly case-flipped, damaged or cut by region end
                        plant_flip = 1'($urandom_range(0, 1));
                        for (int j = 0; j < act_len && pos < rlen; j++)
                        begin
                            b = plant_flip ? flip_case(pat_copy[j]) : pat_copy[j];
                            if ($urandom_range(0, 9) == 0)
                            begin
                                b = b ^ (8'h01 << $urandom_range(0, 7));
                            end
                            send_item(CMD_TEXT, PIDX_W'($urandom), b, pos == rlen - 1);
                            pos++;
                        end
                    end
                    else
                    begin
                        send_item(CMD_TEXT, PIDX_W'($urandom), pick_byte(), pos == rlen - 1);
                        pos++;
                    end
                end
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (fails == 0)
        begin
            $display("substring_search_matcher: match");
        end
        else
        begin
            $display("substring_search_matcher: mismatch");
        end
        $finish;
    end

endmodule
